>>> rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// shared types, codes and helpers for the scoped symbol table
// ----------------------------------------------------------------------------
package sst_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 128;
   localparam int DEFAULT_NAME_BITS   = 32;

   localparam int KIND_BITS    = 3;
   localparam int TAG_BITS     = 32;
   localparam int LEVEL_BITS   = 8;
   localparam int ADDR_BITS    = 16;
   localparam int SCOPE_BITS   = 8;
   localparam int STATUS_BITS  = 2;

   localparam logic [ADDR_BITS-1:0]  ADDR_BASE = 16'd4;
   localparam logic [SCOPE_BITS-1:0] SCOPE_MAX = 8'd255;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_PUSH      = 3'd0,
      KIND_ENTER     = 3'd1,
      KIND_LEAVE     = 3'd2,
      KIND_FIND_NAME = 3'd3,
      KIND_FIND_ADDR = 3'd4
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_UNDERFLOW = 2'd3
   } status_type;

   typedef enum logic {
      STATE_IDLE = 1'b0,
      STATE_SCAN = 1'b1
   } state_type;

   typedef struct packed {
      kind_type               kind;
      logic [ADDR_BITS-1:0]   query_address;
      logic [SCOPE_BITS-1:0]  depth;
   } query_type;

   // slot address of stack entry idx
   function automatic logic [ADDR_BITS-1:0] addr_of(input logic [ADDR_BITS-1:0] idx);
      return (idx << 2) + ADDR_BASE;
   endfunction

endpackage

>>> rtl/sst_entry_ram.sv
// ----------------------------------------------------------------------------
// sst_entry_ram
// entry store: name tag, scope and pointer level, one write and one
// registered read port
// ----------------------------------------------------------------------------
module sst_entry_ram #(
   parameter int TABLE_DEPTH = sst_pkg::DEFAULT_TABLE_DEPTH,
   parameter int NAME_BITS   = sst_pkg::DEFAULT_NAME_BITS,
   parameter int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [IDX_BITS-1:0]              wr_addr,
   input  logic [NAME_BITS-1:0]             wr_name,
   input  logic [sst_pkg::SCOPE_BITS-1:0]   wr_scope,
   input  logic [sst_pkg::LEVEL_BITS-1:0]   wr_level,
   input  logic [IDX_BITS-1:0]              rd_addr,
   output logic [NAME_BITS-1:0]             rd_name,
   output logic [sst_pkg::SCOPE_BITS-1:0]   rd_scope,
   output logic [sst_pkg::LEVEL_BITS-1:0]   rd_level
);
   import sst_pkg::*;

   logic [NAME_BITS-1:0]  name_mem  [TABLE_DEPTH];
   logic [SCOPE_BITS-1:0] scope_mem [TABLE_DEPTH];
   logic [LEVEL_BITS-1:0] level_mem [TABLE_DEPTH];

   logic [NAME_BITS-1:0]  rd_name_ff;
   logic [SCOPE_BITS-1:0] rd_scope_ff;
   logic [LEVEL_BITS-1:0] rd_level_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         name_mem[wr_addr]  <= wr_name;
         scope_mem[wr_addr] <= wr_scope;
         level_mem[wr_addr] <= wr_level;
      end
   end

   always_ff @(posedge clock) begin
      rd_name_ff  <= name_mem[rd_addr];
      rd_scope_ff <= scope_mem[rd_addr];
      rd_level_ff <= level_mem[rd_addr];
   end

   assign rd_name  = rd_name_ff;
   assign rd_scope = rd_scope_ff;
   assign rd_level = rd_level_ff;

endmodule

>>> rtl/sst_match_unit.sv
// ----------------------------------------------------------------------------
// sst_match_unit
// shared compare: name tag, slot address or scope depth against the
// entry read out this cycle
// ----------------------------------------------------------------------------
module sst_match_unit #(
   parameter int TABLE_DEPTH = sst_pkg::DEFAULT_TABLE_DEPTH,
   parameter int NAME_BITS   = sst_pkg::DEFAULT_NAME_BITS,
   parameter int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  sst_pkg::query_type               query,
   input  logic [NAME_BITS-1:0]             query_name,
   input  logic [IDX_BITS-1:0]              entry_idx,
   input  logic [NAME_BITS-1:0]             entry_name,
   input  logic [sst_pkg::SCOPE_BITS-1:0]   entry_scope,
   output logic                             hit
);
   import sst_pkg::*;

   always_comb begin
      case (query.kind)
         KIND_FIND_NAME: hit = (entry_name == query_name);
         KIND_FIND_ADDR: hit = (addr_of(ADDR_BITS'(entry_idx)) == query.query_address);
         KIND_LEAVE:     hit = (entry_scope > query.depth);
         default:        hit = 1'b0;
      endcase
   end

endmodule

>>> rtl/scoped_symbol_table.sv
// ----------------------------------------------------------------------------
// scoped_symbol_table
// scoped symbol stack with push, scope enter/leave and newest-first lookup
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; the req_ ports carry
// the command word. Every command gives exactly one result word, shown on
// the rsp_ ports for one cycle with rsp_valid high; the receiver cannot stall.
// Push, enter scope, unused kinds, a leave at depth zero or in an empty
// table and a lookup in an empty table answer in the cycle after acceptance
// and busy stays low, so such words can be taken on every cycle.
// Lookups and a leave that finds entries walk the stack newest first, one
// entry per cycle through the entry memory's registered read port and the
// shared compare unit. A lookup visits at most TABLE_DEPTH entries (128 at
// the default); a leave visits each dropped entry and, unless the whole
// stack goes, the first entry that stays. Busy is high while the walk runs
// and drops with the result word, so the next word can be taken at the
// edge that ends it.
// Slot addresses follow from the stack position (4 plus 4 per entry).
// Synchronous reset empties the stack, sets depth zero and clears busy and
// the result strobe; the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
module scoped_symbol_table #(
   parameter int TABLE_DEPTH = sst_pkg::DEFAULT_TABLE_DEPTH,
   parameter int NAME_BITS   = sst_pkg::DEFAULT_NAME_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [sst_pkg::KIND_BITS-1:0]     req_kind,
   input  logic [sst_pkg::TAG_BITS-1:0]      req_name_tag,
   input  logic [sst_pkg::LEVEL_BITS-1:0]    req_pointer_level,
   input  logic [sst_pkg::ADDR_BITS-1:0]     req_query_address,
   output logic                              rsp_valid,
   output logic [sst_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [sst_pkg::ADDR_BITS-1:0]     rsp_slot_address,
   output logic [sst_pkg::LEVEL_BITS-1:0]    rsp_found_level,
   output logic [sst_pkg::SCOPE_BITS-1:0]    rsp_found_scope,
   output logic [sst_pkg::SCOPE_BITS-1:0]    rsp_scope_depth
);
   import sst_pkg::*;

   localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] COUNT_FULL = CNT_BITS'(TABLE_DEPTH);

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [SCOPE_BITS-1:0] depth_ff, depth_in;
   kind_type              kind_ff, kind_in;
   logic [NAME_BITS-1:0]  tag_ff, tag_in;
   logic [ADDR_BITS-1:0]  qaddr_ff, qaddr_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [ADDR_BITS-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [LEVEL_BITS-1:0] rsp_level_ff, rsp_level_in;
   logic [SCOPE_BITS-1:0] rsp_scope_ff, rsp_scope_in;
   logic [SCOPE_BITS-1:0] rsp_depth_ff;

   kind_type              req_kind_code;
   logic [CNT_BITS-1:0]   count_dec;
   logic                  table_full;
   logic                  wr_en;
   logic [NAME_BITS-1:0]  rd_name;
   logic [SCOPE_BITS-1:0] rd_scope;
   logic [LEVEL_BITS-1:0] rd_level;
   query_type             query;
   logic                  hit;
   logic                  scan_done;

   assign req_kind_code = kind_type'(req_kind);
   assign count_dec     = count_ff - CNT_BITS'(1);
   assign table_full    = (count_ff == COUNT_FULL);
   assign wr_en         = (state_ff == STATE_IDLE) && start
                          && (req_kind_code == KIND_PUSH) && !table_full;

   assign query = {kind_ff, qaddr_ff, depth_ff};

   sst_entry_ram #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .NAME_BITS   (NAME_BITS),
      .IDX_BITS    (IDX_BITS)
   ) u_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (count_ff[IDX_BITS-1:0]),
      .wr_name  (NAME_BITS'(req_name_tag)),
      .wr_scope (depth_ff),
      .wr_level (req_pointer_level),
      .rd_addr  (idx_in),
      .rd_name  (rd_name),
      .rd_scope (rd_scope),
      .rd_level (rd_level)
   );

   sst_match_unit #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .NAME_BITS   (NAME_BITS),
      .IDX_BITS    (IDX_BITS)
   ) u_match (
      .query       (query),
      .query_name  (tag_ff),
      .entry_idx   (idx_ff),
      .entry_name  (rd_name),
      .entry_scope (rd_scope),
      .hit         (hit)
   );

   // leave keeps popping while entries are deeper; lookups stop on a match
   assign scan_done = (state_ff == STATE_SCAN)
                      && (((kind_ff == KIND_LEAVE) ? !hit : hit) || (idx_ff == '0));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         STATE_IDLE: begin
            if (start) begin
               case (req_kind_code)
                  KIND_LEAVE: begin
                     if ((depth_ff != '0) && (count_ff != '0)) state_in = STATE_SCAN;
                  end
                  KIND_FIND_NAME, KIND_FIND_ADDR: begin
                     if (count_ff != '0) state_in = STATE_SCAN;
                  end
                  default: state_in = STATE_IDLE;
               endcase
            end
         end
         STATE_SCAN: begin
            if (scan_done) state_in = STATE_IDLE;
         end
         default: state_in = STATE_IDLE;
      endcase
   end

   // datapath and result word
   always_comb begin
      count_in      = count_ff;
      depth_in      = depth_ff;
      kind_in       = kind_ff;
      tag_in        = tag_ff;
      qaddr_in      = qaddr_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_slot_in   = '0;
      rsp_level_in  = '0;
      rsp_scope_in  = '0;
      case (state_ff)
         STATE_IDLE: begin
            if (start) begin
               kind_in  = req_kind_code;
               tag_in   = NAME_BITS'(req_name_tag);
               qaddr_in = req_query_address;
               idx_in   = count_dec[IDX_BITS-1:0];
               case (req_kind_code)
                  KIND_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (table_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        count_in    = count_ff + CNT_BITS'(1);
                        rsp_slot_in = addr_of(ADDR_BITS'(count_ff));
                     end
                  end
                  KIND_ENTER: begin
                     rsp_valid_in = 1'b1;
                     if (depth_ff != SCOPE_MAX) depth_in = depth_ff + 8'd1;
                  end
                  KIND_LEAVE: begin
                     if (depth_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_UNDERFLOW;
                     end else begin
                        depth_in = depth_ff - 8'd1;
                        if (count_ff == '0) rsp_valid_in = 1'b1;
                     end
                  end
                  KIND_FIND_NAME, KIND_FIND_ADDR: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_NOT_FOUND;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         STATE_SCAN: begin
            if (kind_ff == KIND_LEAVE) begin
               if (hit) count_in = CNT_BITS'(idx_ff);
            end else if (hit) begin
               rsp_slot_in  = addr_of(ADDR_BITS'(idx_ff));
               rsp_level_in = rd_level;
               rsp_scope_in = rd_scope;
            end
            if (scan_done) begin
               rsp_valid_in = 1'b1;
               if ((kind_ff != KIND_LEAVE) && !hit) rsp_status_in = STATUS_NOT_FOUND;
            end else begin
               idx_in = idx_ff - IDX_BITS'(1);
            end
         end
         default: idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      tag_ff        <= tag_in;
      qaddr_ff      <= qaddr_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_scope_ff  <= rsp_scope_in;
      rsp_depth_ff  <= depth_in;
   end

   assign busy             = (state_ff != STATE_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_address = rsp_slot_ff;
   assign rsp_found_level  = rsp_level_ff;
   assign rsp_found_scope  = rsp_scope_ff;
   assign rsp_scope_depth  = rsp_depth_ff;

`ifndef SYNTHESIS
   // no result word while the stack walk is still running
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_SCAN) |-> !rsp_valid_ff)
      else $error("result strobe during stack walk");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("entry count beyond table depth");

   // a walk never grows the stack
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_SCAN) |=> (count_ff <= $past(count_ff)))
      else $error("entry count grew during stack walk");
`endif

endmodule
